// ===== hdl/range_min_segment_tree_top_defines.svh =====
`ifndef RANGE_MIN_SEGMENT_TREE_TOP_DEFINES_SVH
`define RANGE_MIN_SEGMENT_TREE_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define RMST_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("rmst check failed");

// antecedent implies consequent in the next cycle
`define RMST_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("rmst check failed");

`endif

// ===== hdl/rmst_pkg.sv =====
package rmst_pkg;

    localparam int LEAF_COUNT = 1024;
    localparam int LEAF_AW    = $clog2(LEAF_COUNT);
    localparam int NODE_AW    = LEAF_AW + 1;
    localparam int IDX_W      = 10;
    localparam int DATA_W     = 32;
    localparam int QW         = ((LEAF_AW > IDX_W) ? LEAF_AW : IDX_W) + 2;
    localparam int PADDR_W    = 3;

    typedef logic signed [DATA_W-1:0] node_t;
    typedef logic [NODE_AW-1:0]       node_addr_t;
    typedef logic [IDX_W-1:0]         idx_t;

    localparam node_t INF_VALUE = 32'sh3f3f3f3f;
    localparam idx_t  TOP_RESET = 10'd1023;
    localparam idx_t  TOP_LIMIT = IDX_W'(LEAF_COUNT - 1);

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_QUERY  = 1'b1
    } opcode_t;

    typedef enum logic {
        REG_TOP_INDEX = 1'b0
    } reg_index_t;

    typedef struct packed {
        logic       we;
        node_addr_t addr;
        node_t      wdata;
    } mem_req_t;

    function automatic node_t min_node(input node_t a, input node_t b);
        return (a < b) ? a : b;
    endfunction

endpackage

// ===== hdl/rmst_ifs.sv =====
interface rmst_req_if
    import rmst_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  opcode;
    idx_t  first_index;
    idx_t  last_index;
    node_t new_value;

    modport source (output valid, output opcode, output first_index, output last_index,
                    output new_value, input ready);
    modport sink (input valid, input opcode, input first_index, input last_index,
                  input new_value, output ready);
endinterface

interface rmst_rsp_if
    import rmst_pkg::*;
();
    logic  valid;
    logic  ready;
    node_t range_minimum;

    modport source (output valid, output range_minimum, input ready);
    modport sink (input valid, input range_minimum, output ready);
endinterface

// ===== hdl/rmst_node_ram.sv =====
module rmst_node_ram
    import rmst_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output node_t    rdata
);

    node_t node_mem [2**NODE_AW];
    node_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            node_mem[req.addr] <= req.wdata;
        end
        else
        begin
            rdata_reg <= node_mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/rmst_cfg.sv =====
module rmst_cfg
    import rmst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output idx_t               top_index
);

    idx_t top_reg;
    idx_t top_next;
    logic hit_top;

    assign hit_top = (paddr[PADDR_W-1:2] == REG_TOP_INDEX);

    always_comb
    begin
        top_next = top_reg;
        if (psel && penable && pwrite && hit_top)
        begin
            top_next = pwdata[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= TOP_RESET;
        end
        else
        begin
            top_reg <= top_next;
        end
    end

    assign prdata    = hit_top ? DATA_W'(top_reg) : '0;
    assign pready    = 1'b1;
    assign top_index = top_reg;

endmodule

// ===== hdl/rmst_ctrl.sv =====
module rmst_ctrl
    import rmst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  idx_t     top_index,
    input  node_t    rdata,
    output mem_req_t mem_req,
    rmst_req_if.sink   req,
    rmst_rsp_if.source rsp
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_U_RD   = 8'b0000_0100,
        S_U_LEAF = 8'b0000_1000,
        S_U_SIB  = 8'b0001_0000,
        S_U_PAR  = 8'b0010_0000,
        S_Q_A    = 8'b0100_0000,
        S_Q_B    = 8'b1000_0000
    } state_t;

    state_t        state_reg, state_next;
    node_addr_t    clr_reg, clr_next;
    node_addr_t    node_reg, node_next;
    node_t         val_reg, val_next;
    logic [QW-1:0] qa_reg, qa_next;
    logic [QW-1:0] qb_reg, qb_next;
    node_t         best_reg, best_next;
    logic          pend_reg, pend_next;
    logic          res_valid_reg, res_valid_next;
    node_t         res_reg, res_next;

    idx_t          top_eff;
    idx_t          hi_clip;
    node_t         fold;
    node_t         cur;
    node_addr_t    parent;
    logic [QW-1:0] qb_dec;
    logic          clr_on_path;

    assign top_eff     = (top_index > TOP_LIMIT) ? TOP_LIMIT : top_index;
    assign hi_clip     = (req.last_index > top_eff) ? top_eff : req.last_index;
    assign fold        = pend_reg ? min_node(best_reg, rdata) : best_reg;
    assign qb_dec      = qb_reg - QW'(1);
    assign parent      = node_reg >> 1;
    // leaf 0 and its ancestors sit at power-of-two addresses
    assign clr_on_path = (clr_reg != '0) && ((clr_reg & (clr_reg - NODE_AW'(1))) == '0);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        node_next      = node_reg;
        val_next       = val_reg;
        qa_next        = qa_reg;
        qb_next        = qb_reg;
        best_next      = best_reg;
        pend_next      = pend_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        cur            = val_reg;
        mem_req        = '{we: 1'b0, addr: node_reg, wdata: val_reg};

        if (res_valid_reg && rsp.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_req = '{we: 1'b1, addr: clr_reg,
                            wdata: clr_on_path ? node_t'(0) : INF_VALUE};
                clr_next = clr_reg + NODE_AW'(1);
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.opcode == OP_UPDATE)
                    begin
                        if (req.first_index <= top_eff)
                        begin
                            node_next  = NODE_AW'(LEAF_COUNT) + NODE_AW'(req.first_index);
                            val_next   = req.new_value;
                            state_next = S_U_RD;
                        end
                    end
                    else
                    begin
                        qa_next    = QW'(LEAF_COUNT) + QW'(req.first_index);
                        qb_next    = QW'(LEAF_COUNT) + QW'(hi_clip) + QW'(1);
                        best_next  = INF_VALUE;
                        pend_next  = 1'b0;
                        state_next = S_Q_A;
                    end
                end
            end
            S_U_RD:
            begin
                state_next = S_U_LEAF;
            end
            S_U_LEAF:
            begin
                cur        = min_node(rdata, val_reg);
                mem_req    = '{we: 1'b1, addr: node_reg, wdata: cur};
                val_next   = cur;
                state_next = S_U_SIB;
            end
            S_U_SIB:
            begin
                mem_req.addr = {node_reg[NODE_AW-1:1], ~node_reg[0]};
                state_next   = S_U_PAR;
            end
            S_U_PAR:
            begin
                cur       = min_node(val_reg, rdata);
                mem_req   = '{we: 1'b1, addr: parent, wdata: cur};
                val_next  = cur;
                node_next = parent;
                if (parent == NODE_AW'(1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_U_SIB;
                end
            end
            S_Q_A:
            begin
                best_next = fold;
                pend_next = 1'b0;
                if (qa_reg >= qb_reg)
                begin
                    if (!res_valid_reg || rsp.ready)
                    begin
                        res_next       = fold;
                        res_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    if (qa_reg[0])
                    begin
                        mem_req.addr = qa_reg[NODE_AW-1:0];
                        qa_next      = qa_reg + QW'(1);
                        pend_next    = 1'b1;
                    end
                    state_next = S_Q_B;
                end
            end
            S_Q_B:
            begin
                best_next = fold;
                pend_next = 1'b0;
                if (qb_reg[0])
                begin
                    mem_req.addr = qb_dec[NODE_AW-1:0];
                    pend_next    = 1'b1;
                end
                qa_next    = qa_reg >> 1;
                qb_next    = qb_reg >> 1;
                state_next = S_Q_A;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        val_reg  <= val_next;
        qa_reg   <= qa_next;
        qb_reg   <= qb_next;
        best_reg <= best_next;
        res_reg  <= res_next;
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = res_valid_reg;
    assign rsp.range_minimum = res_reg;

endmodule

// ===== hdl/range_min_segment_tree_top.sv =====
// Range-minimum segment tree over 1024 signed 32-bit leaves held in one single-port node
// memory (2048 x 32, registered read). An update (opcode 0) lowers a leaf to min(old, new_value)
// and rewrites its ancestors; it is ignored when first_index is above top_index. A query
// (opcode 1) returns the minimum over first_index..min(last_index, top_index), or 0x3f3f3f3f
// when that range is empty. Items are handled one at a time. An update in range reads
// and writes the leaf, then does a sibling read and a parent write on each of the 10
// levels; an ignored update leaves the block idle. A query climbs one tree level at a
// time through S_Q_A and S_Q_B, since each level may read up to two nodes through the one
// memory port. After reset the block runs a clearing pass over all 2048 memory words and
// accepts no item until it ends; configuration writes are taken throughout. top_index
// is at byte address 0 of the APB port and does not clear the stored values when rewritten.
module range_min_segment_tree_top
    import rmst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    rmst_req_if.sink           req,
    rmst_rsp_if.source         rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    idx_t     top_index;
    mem_req_t mem_req;
    node_t    rdata;

    rmst_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .top_index (top_index)
    );

    rmst_node_ram u_ram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    rmst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .top_index (top_index),
        .rdata     (rdata),
        .mem_req   (mem_req),
        .req       (req),
        .rsp       (rsp)
    );

endmodule

// ===== hdl/rmst_checker.sv =====
`include "range_min_segment_tree_top_defines.svh"

module rmst_checker
    import rmst_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  req_valid,
    input logic  req_ready,
    input logic  req_opcode,
    input logic  rsp_valid,
    input logic  rsp_ready,
    input node_t rsp_min
);

    `RMST_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `RMST_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp_min))
    `RMST_ASSERT_NEXT(a_update_no_result, clk, rst_n, req_valid && req_ready && (req_opcode == OP_UPDATE), !$rose(rsp_valid))
    `RMST_ASSERT_NEXT(a_query_busy, clk, rst_n, req_valid && req_ready && (req_opcode == OP_QUERY), !req_ready)

endmodule

bind range_min_segment_tree_top rmst_checker u_rmst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_opcode (req.opcode),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_min    (rsp.range_minimum)
);
